>>> rtl/core/tcc_pkg.sv
`default_nettype none
package tcc_pkg;
  localparam int MAX_POINTS = 256;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;

  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_APP_PREV = 3'd1;
  localparam logic [2:0] MODE_APP_CUR = 3'd2;
  localparam logic [2:0] MODE_COMPUTE = 3'd3;
  localparam logic [2:0] MODE_QUERY = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] speed;
    logic signed [31:0] arc_s;
  } in_t;

  typedef struct packed {
    logic signed [31:0] coincidence;
    logic [7:0] nearest_index;
    logic [1:0] status;
    logic overflow_seen;
  } out_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] h;
    logic [31:0] v;
    logic [31:0] s;
  } point_t;

  typedef struct packed {
    logic start;
    logic [63:0] num_mag;
    logic [33:0] den;
  } div_req_t;
endpackage
`default_nettype wire

>>> rtl/core/tcc_store.sv
`default_nettype none
module tcc_store (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [tcc_pkg::IDX_W-1:0] waddr,
  input  wire tcc_pkg::point_t wdata,
  input  wire logic [tcc_pkg::IDX_W-1:0] raddr,
  output tcc_pkg::point_t rdata
);
  tcc_pkg::point_t mem [tcc_pkg::MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/tcc_div.sv
`default_nettype none
module tcc_div (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire tcc_pkg::div_req_t req,
  output logic busy,
  output logic [63:0] quot
);
  logic [63:0] q_r;
  logic [64:0] rem_r;
  logic [33:0] den_r;
  logic [6:0] cnt_r;
  logic [64:0] trial;

  assign trial = {rem_r[63:0], q_r[63]} - {31'd0, den_r};
  assign busy = cnt_r != 7'd0;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 7'd0;
    end else if (req.start) begin
      cnt_r <= 7'd64;
      q_r <= req.num_mag;
      rem_r <= 65'd0;
      den_r <= req.den;
    end else if (busy) begin
      cnt_r <= cnt_r - 7'd1;
      if (!trial[64]) begin
        rem_r <= trial;
        q_r <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[63:0], q_r[63]};
        q_r <= {q_r[62:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/trajectory_coincidence_cost.sv
// Append and clear are accepted one beat per cycle while idle and the output is not held.
// Query scans the Nc current points with one store read per cycle.
// Compute runs two nearest scans (over Np, then over Np or Nc), sums four terms per
// aligned pair and runs a 64-step restoring divider. The block stalls input meanwhile.
// Synchronous active-low reset clears counts, the drop flag and the sequencer.
`default_nettype none
module trajectory_coincidence_cost (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire tcc_pkg::in_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output tcc_pkg::out_t out_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ENDS = 4'd1;
  localparam logic [3:0] S_NSCAN = 4'd2;
  localparam logic [3:0] S_NDONE = 4'd3;
  localparam logic [3:0] S_SFETCH = 4'd4;
  localparam logic [3:0] S_PAIR = 4'd5;
  localparam logic [3:0] S_DIVGO = 4'd6;
  localparam logic [3:0] S_DIVW = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;
  localparam logic [3:0] S_ENDW = 4'd9;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_Q = 2'd2;

  logic [3:0] state_r;
  logic [tcc_pkg::CNT_W-1:0] pcnt_r, ccnt_r;
  logic drop_r;
  logic out_valid_r;
  tcc_pkg::out_t out_r;

  logic pwe, cwe;
  logic [tcc_pkg::IDX_W-1:0] praddr, craddr;
  tcc_pkg::point_t pw, prd, crd;

  logic [1:0] phase_r;
  logic scan_cur_r;
  logic [tcc_pkg::CNT_W-1:0] i_r, n_r;
  logic rv_r;
  logic [tcc_pkg::CNT_W-1:0] ri_r;
  logic signed [31:0] qx_r, qy_r;
  logic [64:0] best_r;
  logic have_r;
  logic [tcc_pkg::CNT_W-1:0] best_i_r, a_r, b_r, end_r;
  logic [1:0] ends_r;
  logic signed [31:0] ps0_r, psl_r, cs0_r, csl_r, sa_r, sb_r;
  logic [31:0] c0x_r, c0y_r, clx_r, cly_r, plx_r, ply_r;
  logic pfar_r;
  logic [63:0] sum_r;
  logic [33:0] ad_r;
  logic [1:0] k_r;
  logic pair_ok_r;
  tcc_pkg::div_req_t dreq;
  logic dbusy;
  logic [63:0] dq;
  logic neg_r;

  logic signed [32:0] dx, dy;
  logic [32:0] ax, ay;
  logic [64:0] sq_dist;

  tcc_store u_prev (.clk, .we(pwe), .waddr(pcnt_r[tcc_pkg::IDX_W-1:0]), .wdata(pw),
    .raddr(praddr), .rdata(prd));
  tcc_store u_cur (.clk, .we(cwe), .waddr(ccnt_r[tcc_pkg::IDX_W-1:0]), .wdata(pw),
    .raddr(craddr), .rdata(crd));
  tcc_div u_div (.clk, .rst_n, .req(dreq), .busy(dbusy), .quot(dq));

  logic acc;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign acc = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign pw = '{x: in_data.pos_x, y: in_data.pos_y, h: in_data.heading,
                v: in_data.speed, s: in_data.arc_s};
  assign pwe = acc && in_data.mode == tcc_pkg::MODE_APP_PREV &&
               pcnt_r < tcc_pkg::CNT_W'(tcc_pkg::MAX_POINTS);
  assign cwe = acc && in_data.mode == tcc_pkg::MODE_APP_CUR &&
               ccnt_r < tcc_pkg::CNT_W'(tcc_pkg::MAX_POINTS);

  // scan data
  tcc_pkg::point_t sd;
  assign sd = scan_cur_r ? crd : prd;
  assign dx = $signed({qx_r[31], qx_r}) - $signed({sd.x[31], sd.x});
  assign dy = $signed({qy_r[31], qy_r}) - $signed({sd.y[31], sd.y});
  assign ax = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay = dy[32] ? 33'(-dy) : 33'(dy);
  logic [63:0] sqx_r, sqy_r;
  logic sqv_r;
  logic [tcc_pkg::CNT_W-1:0] sqi_r;
  assign sq_dist = {1'b0, sqx_r} + {1'b0, sqy_r};

  // pair term select
  logic [31:0] pa, ca;
  always_comb begin
    case (k_r)
      2'd0: begin pa = prd.x; ca = crd.x; end
      2'd1: begin pa = prd.y; ca = crd.y; end
      2'd2: begin pa = prd.h; ca = crd.h; end
      default: begin pa = prd.v; ca = crd.v; end
    endcase
  end
  logic signed [32:0] pd;
  assign pd = $signed({ca[31], ca}) - $signed({pa[31], pa});

  always_comb begin
    praddr = i_r[tcc_pkg::IDX_W-1:0];
    craddr = i_r[tcc_pkg::IDX_W-1:0];
    if (state_r == S_PAIR) begin
      craddr = 8'(i_r - a_r);
    end
  end

  // numerator pieces
  logic signed [34:0] extra, total;
  logic signed [65:0] num;
  assign extra = 35'(sa_r) - 35'(ps0_r) + (pfar_r ? 35'(psl_r) - 35'(sb_r)
                                                  : 35'(csl_r) - 35'(sb_r));
  assign total = 35'(csl_r) - 35'(cs0_r) + 35'(psl_r) - 35'(ps0_r);
  assign num = $signed({2'b0, sum_r}) + 66'(extra);

  always_comb begin
    dreq.start = state_r == S_DIVGO && total > 0;
    dreq.num_mag = num[65] ? 64'(-num) << 16 : 64'(num) << 16;
    dreq.den = 34'(total);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pcnt_r <= '0;
      ccnt_r <= '0;
      drop_r <= 1'b0;
      out_valid_r <= 1'b0;
      rv_r <= 1'b0;
      sqv_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (pwe) pcnt_r <= pcnt_r + 1'b1;
      if (cwe) ccnt_r <= ccnt_r + 1'b1;
      if (acc && (in_data.mode == tcc_pkg::MODE_APP_PREV) && !pwe) drop_r <= 1'b1;
      if (acc && (in_data.mode == tcc_pkg::MODE_APP_CUR) && !cwe) drop_r <= 1'b1;
      sqv_r <= 1'b0;
      rv_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            out_r.coincidence <= '0;
            out_r.nearest_index <= '0;
            out_r.status <= tcc_pkg::ST_OK;
            unique case (in_data.mode)
              tcc_pkg::MODE_CLEAR: begin
                pcnt_r <= '0;
                ccnt_r <= '0;
                drop_r <= 1'b0;
              end
              tcc_pkg::MODE_QUERY: begin
                if (ccnt_r == '0) begin
                  out_r.status <= tcc_pkg::ST_EMPTY;
                  state_r <= S_OUT;
                end else begin
                  qx_r <= in_data.pos_x;
                  qy_r <= in_data.pos_y;
                  scan_cur_r <= 1'b1;
                  n_r <= ccnt_r;
                  i_r <= '0;
                  have_r <= 1'b0;
                  phase_r <= PH_Q;
                  state_r <= S_NSCAN;
                end
              end
              tcc_pkg::MODE_COMPUTE: begin
                if (ccnt_r == '0 || pcnt_r == '0) begin
                  out_r.status <= tcc_pkg::ST_EMPTY;
                  state_r <= S_OUT;
                end else begin
                  i_r <= '0;
                  ends_r <= 2'd0;
                  state_r <= S_ENDS;
                end
              end
              default: ;
            endcase
          end
        end
        S_ENDS: begin
          // read first then last of each store
          ends_r <= ends_r + 2'd1;
          i_r <= (ends_r == 2'd0) ? pcnt_r - 1'b1 : '0;
          state_r <= S_ENDW;
        end
        S_ENDW: begin
          if (ends_r == 2'd1) begin
            ps0_r <= prd.s;
            cs0_r <= crd.s;
            c0x_r <= crd.x;
            c0y_r <= crd.y;
            i_r <= pcnt_r - 1'b1;
            state_r <= S_ENDS;
          end else if (ends_r == 2'd2) begin
            psl_r <= prd.s;
            plx_r <= prd.x;
            ply_r <= prd.y;
            i_r <= ccnt_r - 1'b1;
            ends_r <= 2'd3;
          end else begin
            ends_r <= 2'd0;
            if (ends_r == 2'd3 && !rv_r) begin
              rv_r <= 1'b1;
            end else begin
              csl_r <= crd.s;
              clx_r <= crd.x;
              cly_r <= crd.y;
              qx_r <= c0x_r;
              qy_r <= c0y_r;
              scan_cur_r <= 1'b0;
              n_r <= pcnt_r;
              i_r <= '0;
              have_r <= 1'b0;
              phase_r <= PH_A;
              state_r <= S_NSCAN;
            end
            if (ends_r == 2'd3 && !rv_r) ends_r <= 2'd3;
          end
        end
        S_NSCAN: begin
          if (i_r < n_r) begin
            i_r <= i_r + 1'b1;
            rv_r <= 1'b1;
            ri_r <= i_r;
          end
          if (rv_r) begin
            sqx_r <= 64'(ax) * 64'(ax);
            sqy_r <= 64'(ay) * 64'(ay);
            sqv_r <= 1'b1;
            sqi_r <= ri_r;
          end
          if (sqv_r) begin
            if (!have_r || sq_dist < best_r) begin
              have_r <= 1'b1;
              best_r <= sq_dist;
              best_i_r <= sqi_r;
            end
          end
          if (i_r >= n_r && !rv_r && !sqv_r) state_r <= S_NDONE;
        end
        S_NDONE: begin
          unique case (phase_r)
            PH_Q: begin
              out_r.nearest_index <= best_i_r[7:0];
              state_r <= S_OUT;
            end
            PH_A: begin
              a_r <= best_i_r;
              pfar_r <= psl_r > csl_r;
              if (psl_r > csl_r) begin
                qx_r <= clx_r;
                qy_r <= cly_r;
                scan_cur_r <= 1'b0;
                n_r <= pcnt_r;
              end else begin
                qx_r <= plx_r;
                qy_r <= ply_r;
                scan_cur_r <= 1'b1;
                n_r <= ccnt_r;
              end
              i_r <= '0;
              have_r <= 1'b0;
              phase_r <= PH_B;
              state_r <= S_NSCAN;
            end
            default: begin
              b_r <= best_i_r;
              end_r <= pfar_r ? best_i_r : pcnt_r;
              // fetch s at a and b
              i_r <= a_r;
              ends_r <= 2'd0;
              state_r <= S_SFETCH;
            end
          endcase
        end
        S_SFETCH: begin
          ends_r <= ends_r + 2'd1;
          if (ends_r == 2'd0) i_r <= b_r;
          if (ends_r == 2'd1) sa_r <= prd.s;
          if (ends_r == 2'd2) begin
            sb_r <= pfar_r ? prd.s : crd.s;
            i_r <= a_r;
            sum_r <= '0;
            k_r <= 2'd0;
            pair_ok_r <= 1'b0;
            state_r <= S_PAIR;
          end
        end
        S_PAIR: begin
          // wait for the store read, then four terms per pair
          if (!pair_ok_r) begin
            pair_ok_r <= 1'b1;
            k_r <= 2'd0;
            if (i_r >= end_r) state_r <= S_DIVGO;
          end else begin
            if ((i_r - a_r) < ccnt_r) sum_r <= sum_r + 64'(pd[32] ? 33'(-pd) : 33'(pd));
            k_r <= k_r + 2'd1;
            if (k_r == 2'd3) begin
              i_r <= i_r + 1'b1;
              pair_ok_r <= 1'b0;
            end
          end
        end
        S_DIVGO: begin
          neg_r <= num[65];
          if (total <= 0) begin
            out_r.status <= tcc_pkg::ST_BADLEN;
            state_r <= S_OUT;
          end else begin
            state_r <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (!dbusy) begin
            if (neg_r) out_r.coincidence <= (dq > 64'h8000_0000) ? 32'h8000_0000
                                              : 32'(-dq);
            else out_r.coincidence <= (dq > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dq[31:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_r.overflow_seen <= drop_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
